@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, antecedent and consequent given as one property
`define LBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg
// constants and codes for the linear blend skinning block
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

    localparam int BONE_COUNT  = 64;
    localparam int INFLUENCES  = 4;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_FRAC = 15;

    localparam int PAL_DEPTH = BONE_COUNT * 16;
    localparam int BONE_W    = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int ADDR_W    = $clog2(PAL_DEPTH);

    // accumulator widths
    localparam int PROD_W = 66;
    localparam int ACC_W  = 68 - FRAC_BITS;
    localparam int SUM_W  = 36;
    localparam int DIV_W  = 32 + FRAC_BITS;
    localparam int IT_W   = $clog2(DIV_W);

    // operation codes
    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_POS     = 3'd2;
    localparam logic [2:0] OP_NORMAL  = 3'd3;
    localparam logic [2:0] OP_TANGENT = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_POS     = 2'd0;
    localparam logic [1:0] KIND_NORMAL  = 2'd1;
    localparam logic [1:0] KIND_TANGENT = 2'd2;

    typedef logic signed [31:0] q16_t;

endpackage

`default_nettype wire

@@ hdl/lbs_ram.sv @@
// ----------------------------------------------------------------------------
// lbs_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/linear_blend_skinning.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skinning
// four-influence vertex skinning in q16.16 with a shared 33x33 multiplier
// ----------------------------------------------------------------------------
// palette write and set-influence items give no result
// position items read, multiply and add each matrix element in turn
// normal and tangent add squares, a 32-step root and 48-step divides
// one item at a time; set by the sequencer around the one multiplier and ram port
// reset clears control, indices and weights; the palette is undefined until written
`default_nettype none

`include "assert_macros.svh"

module linear_blend_skinning
    import lbs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // bone[5:0] element[9:6] value[41:10] influence_indices[73:42]
    // influence_weights[137:74] vec_x[169:138] vec_y[201:170] vec_z[233:202]
    input  wire logic [239:0] s_axis_tdata,
    // operation[2:0]
    input  wire logic [2:0]   s_axis_tuser,
    // result items
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x[31:0] out_y[63:32] out_z[95:64]
    output logic      [95:0]  m_axis_tdata,
    // out_kind[1:0] zero_length[2]
    output logic      [2:0]   m_axis_tuser
);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BONE = 4'd1;   // pick next influence
    localparam logic [3:0] ST_ADDR = 4'd2;   // issue palette read
    localparam logic [3:0] ST_DATA = 4'd3;   // palette data in, multiply or add translation
    localparam logic [3:0] ST_ACC  = 4'd4;   // add shifted product
    localparam logic [3:0] ST_SAT  = 4'd5;   // saturate term, times weight
    localparam logic [3:0] ST_WACC = 4'd6;   // add weighted term
    localparam logic [3:0] ST_FIN  = 4'd7;   // saturate sums
    localparam logic [3:0] ST_SQ   = 4'd8;   // square one component
    localparam logic [3:0] ST_SQA  = 4'd9;   // add square
    localparam logic [3:0] ST_SQRT = 4'd10;  // integer root, two bits a step
    localparam logic [3:0] ST_DLD  = 4'd11;  // load one divide
    localparam logic [3:0] ST_DIV  = 4'd12;  // restoring divide, one bit a step
    localparam logic [3:0] ST_OUT  = 4'd13;  // hand result to output register

    // input fields
    logic [5:0]  in_bone;
    logic [3:0]  in_element;
    logic [31:0] in_value;
    logic [31:0] in_indices;
    logic [63:0] in_weights;
    logic [31:0] in_vx, in_vy, in_vz;
    logic        in_accept;

    assign in_bone    = s_axis_tdata[5:0];
    assign in_element = s_axis_tdata[9:6];
    assign in_value   = s_axis_tdata[41:10];
    assign in_indices = s_axis_tdata[73:42];
    assign in_weights = s_axis_tdata[137:74];
    assign in_vx      = s_axis_tdata[169:138];
    assign in_vy      = s_axis_tdata[201:170];
    assign in_vz      = s_axis_tdata[233:202];
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    // state
    logic [3:0]        state_reg, state_next;
    logic [2:0]        k_reg, k_next;
    logic [1:0]        j_reg, j_next;
    logic [1:0]        r_reg, r_next;
    logic [IT_W-1:0]   it_reg, it_next;
    logic [31:0]       idx_reg, idx_next;
    logic [63:0]       wgt_reg, wgt_next;
    logic [1:0]        kind_reg, kind_next;
    q16_t              v_reg [3];
    q16_t              v_next [3];
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [SUM_W-1:0] sum_next [3];
    logic [31:0]       res_reg [3];
    logic [31:0]       res_next [3];
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [63:0]       len2_reg, len2_next;
    logic [63:0]       n_reg, n_next;
    logic [63:0]       root_reg, root_next;
    logic [63:0]       bit_reg, bit_next;
    logic [31:0]       len_reg, len_next;
    logic [32:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]  dq_reg, dq_next;
    logic              zero_reg, zero_next;
    logic              out_valid_reg, out_valid_next;
    logic [95:0]       out_data_reg, out_data_next;
    logic [2:0]        out_user_reg, out_user_next;

    // palette ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    lbs_ram #(
        .WIDTH (32),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (in_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // current influence
    logic [7:0]  cur_bone;
    logic [15:0] cur_weight;
    assign cur_bone   = idx_reg[k_reg[1:0]*8 +: 8];
    assign cur_weight = wgt_reg[k_reg[1:0]*16 +: 16];

    assign ram_we    = in_accept && (s_axis_tuser == OP_WRITE)
                       && ({3'b000, in_bone} < 9'(BONE_COUNT));
    assign ram_waddr = ADDR_W'({in_bone[BONE_W-1:0], in_element});
    assign ram_re    = (state_reg == ST_ADDR);
    assign ram_raddr = ADDR_W'({cur_bone[BONE_W-1:0], r_reg, j_reg});

    // saturation of the column term
    logic [ACC_W-32:0] acc_hi;
    logic [31:0]       acc_sat;
    assign acc_hi  = acc_reg[ACC_W-1:31];
    assign acc_sat = ((acc_hi == '0) || (acc_hi == '1)) ? acc_reg[31:0]
                   : (acc_reg[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);

    // saturation of the weighted sums
    logic [31:0] sum_sat [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if ((sum_reg[i][SUM_W-1:31] == '0) || (sum_reg[i][SUM_W-1:31] == '1))
            begin
                sum_sat[i] = sum_reg[i][31:0];
            end
            else
            begin
                sum_sat[i] = sum_reg[i][SUM_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
        end
    end

    // magnitude of the selected result component
    logic [31:0] res_sel;
    logic [31:0] res_abs;
    assign res_sel = res_reg[j_reg];
    assign res_abs = res_sel[31] ? (~res_sel + 32'd1) : res_sel;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    q16_t               v_sel;
    always_comb
    begin
        case (r_reg)
            2'd0:    v_sel = v_reg[0];
            2'd1:    v_sel = v_reg[1];
            default: v_sel = v_reg[2];
        endcase
        mul_a = 33'(v_sel);
        mul_b = 33'(signed'(ram_rdata));
        if (state_reg == ST_SAT)
        begin
            mul_a = 33'(signed'(acc_sat));
            mul_b = {17'b0, cur_weight};
        end
        else if (state_reg == ST_SQ)
        begin
            mul_a = {1'b0, res_abs};
            mul_b = {1'b0, res_abs};
        end
    end

    // root and divide steps
    logic [63:0] root_try;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [DIV_W-1:0] dq_step;
    assign root_try = root_reg + bit_reg;
    assign rem_sh   = {rem_reg[31:0], dq_reg[DIV_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, len_reg};
    assign dq_step  = {dq_reg[DIV_W-2:0], rem_ge};

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        it_next        = it_reg;
        idx_next       = idx_reg;
        wgt_next       = wgt_reg;
        kind_next      = kind_reg;
        v_next         = v_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        prod_next      = prod_reg;
        len2_next      = len2_reg;
        n_next         = n_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        OP_SET:
                        begin
                            idx_next = in_indices;
                            wgt_next = in_weights;
                        end
                        OP_POS, OP_NORMAL, OP_TANGENT:
                        begin
                            kind_next  = 2'(s_axis_tuser - OP_POS);
                            v_next[0]  = signed'(in_vx);
                            v_next[1]  = signed'(in_vy);
                            v_next[2]  = signed'(in_vz);
                            for (int i = 0; i < 3; i++)
                            begin
                                sum_next[i] = '0;
                            end
                            zero_next  = 1'b0;
                            k_next     = '0;
                            state_next = ST_BONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BONE:
            begin
                if (k_reg == 3'(INFLUENCES))
                begin
                    state_next = ST_FIN;
                end
                else if ({1'b0, cur_bone} >= 9'(BONE_COUNT))
                begin
                    k_next = k_reg + 3'd1;
                end
                else
                begin
                    j_next     = '0;
                    r_next     = '0;
                    acc_next   = '0;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (r_reg == 2'd3)
                begin
                    acc_next   = acc_reg + ACC_W'(signed'(ram_rdata));
                    state_next = ST_SAT;
                end
                else
                begin
                    prod_next  = mul_a * mul_b;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
                if (r_reg == 2'd2)
                begin
                    if (kind_reg == KIND_POS)
                    begin
                        r_next     = 2'd3;
                        state_next = ST_ADDR;
                    end
                    else
                    begin
                        state_next = ST_SAT;
                    end
                end
                else
                begin
                    r_next     = r_reg + 2'd1;
                    state_next = ST_ADDR;
                end
            end
            ST_SAT:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                sum_next[j_reg] = sum_reg[j_reg] + SUM_W'(prod_reg >>> WEIGHT_FRAC);
                if (j_reg == 2'd2)
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_BONE;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    r_next     = '0;
                    acc_next   = '0;
                    state_next = ST_ADDR;
                end
            end
            ST_FIN:
            begin
                res_next = sum_sat;
                j_next   = '0;
                if (kind_reg == KIND_POS)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    len2_next  = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_SQA;
            end
            ST_SQA:
            begin
                len2_next = len2_reg + prod_reg[63:0];
                if (j_reg == 2'd2)
                begin
                    j_next = '0;
                    if (len2_next == '0)
                    begin
                        zero_next = 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            res_next[i] = '0;
                        end
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        n_next     = len2_next;
                        root_next  = '0;
                        bit_next   = 64'h4000_0000_0000_0000;
                        it_next    = '0;
                        state_next = ST_SQRT;
                    end
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = ST_SQ;
                end
            end
            ST_SQRT:
            begin
                if (n_reg >= root_try)
                begin
                    n_next    = n_reg - root_try;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                it_next  = it_reg + IT_W'(1);
                if (it_reg == IT_W'(31))
                begin
                    len_next   = root_next[31:0];
                    state_next = ST_DLD;
                end
            end
            ST_DLD:
            begin
                rem_next   = '0;
                dq_next    = {res_abs, FRAC_BITS'(0)};
                it_next    = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? (rem_sh - {1'b0, len_reg}) : rem_sh;
                dq_next  = dq_step;
                it_next  = it_reg + IT_W'(1);
                if (it_reg == IT_W'(DIV_W - 1))
                begin
                    res_next[j_reg] = res_sel[31] ? (~dq_step[31:0] + 32'd1) : dq_step[31:0];
                    if (j_reg == 2'd2)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = ST_DLD;
                    end
                end
            end
            ST_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_reg[2], res_reg[1], res_reg[0]};
                    out_user_next  = {zero_reg, kind_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and the influence registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            wgt_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            r_reg         <= '0;
            it_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            wgt_reg       <= wgt_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            r_reg         <= r_next;
            it_reg        <= it_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        v_reg        <= v_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
        prod_reg     <= prod_next;
        len2_reg     <= len2_next;
        n_reg        <= n_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // checks
    `LBS_ASSERT(a_div_len_nonzero, (state_reg == ST_DIV) |-> (len_reg != '0), "zero divisor")
    `LBS_ASSERT(a_zero_not_pos, (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] != KIND_POS), "zero flag on position")
    `LBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "result changed while stalled")

endmodule

`default_nettype wire
